// File: sv/grs_pkg.sv
// ============================================================================
// grs_pkg - shared types and constants for the glyph raster scaler
// Source glyph geometry, load counter width, register indexes and the
// per-width step table used by the coordinate stepping logic.
// ============================================================================
`default_nettype none

package grs_pkg;

    // Source glyph geometry and output limit
    localparam int SRC_HEIGHT = 32;
    localparam int SRC_WIDTH  = 16;
    localparam int MAX_WIDTH  = 32;

    localparam int LOAD_W = $clog2(SRC_HEIGHT);

    // Configuration register indexes
    localparam logic [1:0] CFG_GLYPH_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_BOLD_ENABLE   = 2'd1;
    localparam logic [1:0] CFG_ITALIC_ENABLE = 2'd2;

    // Quotient and remainder of SRC_WIDTH by the effective width
    typedef struct packed {
        logic [4:0] q;
        logic [4:0] r;
    } step_t;

    // SRC_WIDTH / w and SRC_WIDTH % w for w in 1..32, as a table
    function automatic step_t step_of(input logic [5:0] w);
        step_t s;
        s.q = 5'd0;
        s.r = 5'd0;
        case (w) inside
            6'd1:  begin s.q = 5'd16; s.r = 5'd0;  end
            6'd2:  begin s.q = 5'd8;  s.r = 5'd0;  end
            6'd3:  begin s.q = 5'd5;  s.r = 5'd1;  end
            6'd4:  begin s.q = 5'd4;  s.r = 5'd0;  end
            6'd5:  begin s.q = 5'd3;  s.r = 5'd1;  end
            6'd6:  begin s.q = 5'd2;  s.r = 5'd4;  end
            6'd7:  begin s.q = 5'd2;  s.r = 5'd2;  end
            6'd8:  begin s.q = 5'd2;  s.r = 5'd0;  end
            6'd9:  begin s.q = 5'd1;  s.r = 5'd7;  end
            6'd10: begin s.q = 5'd1;  s.r = 5'd6;  end
            6'd11: begin s.q = 5'd1;  s.r = 5'd5;  end
            6'd12: begin s.q = 5'd1;  s.r = 5'd4;  end
            6'd13: begin s.q = 5'd1;  s.r = 5'd3;  end
            6'd14: begin s.q = 5'd1;  s.r = 5'd2;  end
            6'd15: begin s.q = 5'd1;  s.r = 5'd1;  end
            6'd16: begin s.q = 5'd1;  s.r = 5'd0;  end
            [6'd17:6'd32]: begin s.q = 5'd0; s.r = 5'd16; end
            default: begin s.q = 5'd0; s.r = 5'd0; end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: sv/glyph_raster_scaler.sv
// ============================================================================
// glyph_raster_scaler - nearest-neighbor bitmap glyph scaler
// Loads a 16x32 source glyph row by row and emits 2*w scaled rows with
// optional bold and italic.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall, row_bits): one source row per word,
//   bit 15 is the leftmost pixel. Rows fill slots 0..31 in order; the word
//   that fills slot 31 starts emission of the scaled glyph.
//   Output channel (out_valid/out_stall): pixel_row (bit 31 is column 0),
//   row_number and last_row. A glyph of effective width w (1..32) yields
//   2*w words.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready.
//   Registers are sampled when the 32nd row is accepted.
// Sequence:
//   Each output row passes through the registered glyph store read
//   (FETCH), the shared column stepper (one add/compare per column) and
//   the hand-off of the row to the output register (PUT). in_stall is
//   high for the whole emission.
// Reset:
//   Clears the load slot, sequencer and output valid; registers return to
//   width 16, bold off, italic off. Glyph store contents are not cleared.
// Stall:
//   A stalled output word holds; the sequencer waits with the next row
//   until the output register frees up.
// ============================================================================
`default_nettype none

module glyph_raster_scaler
    import grs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] row_bits,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      pixel_row,
    output logic [5:0]       row_number,
    output logic             last_row,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [5:0]  cfg_data
);

    // Sequencer codes
    localparam logic [1:0] ST_LOAD  = 2'd0;  // taking source rows
    localparam logic [1:0] ST_FETCH = 2'd1;  // store read in flight
    localparam logic [1:0] ST_COLS  = 2'd2;  // one column per cycle
    localparam logic [1:0] ST_PUT   = 2'd3;  // hand row to output reg

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [1:0]        state_reg, state_next;
    logic [LOAD_W-1:0] load_cnt_reg, load_cnt_next;

    logic [5:0]  glyph_width_reg;
    logic        bold_enable_reg;
    logic        italic_enable_reg;

    // glyph parameters latched at emission start
    logic [5:0]  w_reg, w_next;        // effective width
    logic [5:0]  d_reg, d_next;        // 2w-1, also last row number
    logic [3:0]  smax_reg, smax_next;  // max(1, w/4)
    logic [4:0]  qinc_reg, qinc_next;  // 16 / w
    logic [4:0]  rinc_reg, rinc_next;  // 16 % w
    logic        bold_reg, bold_next;
    logic        italic_reg, italic_next;

    // row stepping: sy = r*16/w, shear = (d-r)*smax/d
    logic [5:0]  row_reg, row_next;
    logic [4:0]  syq_reg, syq_next;
    logic [5:0]  syr_reg, syr_next;
    logic [3:0]  shq_reg, shq_next;
    logic [5:0]  shr_reg, shr_next;

    // column stepping: sx = (c-shear)*16/w
    logic [4:0]  col_reg, col_next;
    logic [4:0]  cq_reg, cq_next;
    logic [5:0]  cr_reg, cr_next;
    logic [31:0] acc_reg, acc_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] pixel_row_reg;
    logic [5:0]  row_number_reg;
    logic        last_row_reg;

    // glyph store, registered read
    logic [15:0] glyph_mem [SRC_HEIGHT];
    logic [15:0] rd_data_reg;

    // ------------------------------------------------------------------
    // Combinational
    // ------------------------------------------------------------------
    logic        in_fire;
    logic        start;
    logic        put_fire;
    logic        is_last;
    logic [5:0]  w_eff;
    step_t       stp;
    logic [15:0] src;
    logic [3:0]  shear;
    logic [6:0]  row_rsum;
    logic [5:0]  row_qsum;
    logic [6:0]  col_rsum;
    logic [5:0]  col_qsum;
    logic signed [7:0] sh_diff;

    assign in_stall  = (state_reg != ST_LOAD);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && !in_stall;
    assign start     = in_fire && (load_cnt_reg == LOAD_W'(SRC_HEIGHT - 1));
    assign put_fire  = (state_reg == ST_PUT) && (!out_valid_reg || !out_stall);
    assign is_last   = (row_reg == d_reg);

    // width 0 acts as 1, widths above the limit saturate
    always_comb
    begin
        if (glyph_width_reg == 6'd0)
            w_eff = 6'd1;
        else if (glyph_width_reg > 6'(MAX_WIDTH))
            w_eff = 6'(MAX_WIDTH);
        else
            w_eff = glyph_width_reg;
    end

    assign stp   = step_of(w_eff);
    assign src   = bold_reg ? (rd_data_reg | (rd_data_reg >> 1)) : rd_data_reg;
    assign shear = italic_reg ? shq_reg : 4'd0;

    // shared stepper adds
    assign row_rsum = {1'b0, syr_reg} + {2'b00, rinc_reg};
    assign row_qsum = {1'b0, syq_reg} + {1'b0, qinc_reg};
    assign col_rsum = {1'b0, cr_reg} + {2'b00, rinc_reg};
    assign col_qsum = {1'b0, cq_reg} + {1'b0, qinc_reg};
    assign sh_diff  = $signed({2'b00, shr_reg}) - $signed({4'b0000, smax_reg});

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        w_next        = w_reg;
        d_next        = d_reg;
        smax_next     = smax_reg;
        qinc_next     = qinc_reg;
        rinc_next     = rinc_reg;
        bold_next     = bold_reg;
        italic_next   = italic_reg;
        row_next      = row_reg;
        syq_next      = syq_reg;
        syr_next      = syr_reg;
        shq_next      = shq_reg;
        shr_next      = shr_reg;
        col_next      = col_reg;
        cq_next       = cq_reg;
        cr_next       = cr_reg;
        acc_next      = acc_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                    load_cnt_next = load_cnt_reg + LOAD_W'(1);
                if (start)
                begin
                    w_next      = w_eff;
                    d_next      = 6'((7'(w_eff) << 1) - 7'd1);
                    smax_next   = (w_eff < 6'd4) ? 4'd1 : 4'(w_eff >> 2);
                    qinc_next   = stp.q;
                    rinc_next   = stp.r;
                    bold_next   = bold_enable_reg;
                    italic_next = italic_enable_reg;
                    row_next    = 6'd0;
                    syq_next    = 5'd0;
                    syr_next    = 6'd0;
                    shq_next    = (w_eff < 6'd4) ? 4'd1 : 4'(w_eff >> 2);
                    shr_next    = 6'd0;
                    state_next  = ST_FETCH;
                end
            end

            ST_FETCH:
            begin
                col_next   = 5'd0;
                cq_next    = 5'd0;
                cr_next    = 6'd0;
                acc_next   = 32'd0;
                state_next = ST_COLS;
            end

            ST_COLS:
            begin
                // sheared-off columns stay blank and do not step sx
                if (col_reg >= 5'(shear))
                begin
                    if (cq_reg < 5'(SRC_WIDTH) && src[4'(SRC_WIDTH - 1) - cq_reg[3:0]])
                        acc_next[5'd31 - col_reg] = 1'b1;
                    if (col_rsum >= {1'b0, w_reg})
                    begin
                        cr_next = 6'(col_rsum - {1'b0, w_reg});
                        cq_next = 5'(col_qsum + 6'd1);
                    end
                    else
                    begin
                        cr_next = col_rsum[5:0];
                        cq_next = col_qsum[4:0];
                    end
                end
                col_next = col_reg + 5'd1;
                if ({1'b0, col_reg} == w_reg - 6'd1)
                    state_next = ST_PUT;
            end

            ST_PUT:
            begin
                if (put_fire)
                begin
                    if (is_last)
                        state_next = ST_LOAD;
                    else
                    begin
                        row_next = row_reg + 6'd1;
                        if (row_rsum >= {1'b0, w_reg})
                        begin
                            syr_next = 6'(row_rsum - {1'b0, w_reg});
                            syq_next = 5'(row_qsum + 6'd1);
                        end
                        else
                        begin
                            syr_next = row_rsum[5:0];
                            syq_next = row_qsum[4:0];
                        end
                        if (sh_diff < 0)
                        begin
                            shr_next = 6'(sh_diff + $signed({2'b00, d_reg}));
                            shq_next = shq_reg - 4'd1;
                        end
                        else
                            shr_next = sh_diff[5:0];
                        state_next = ST_FETCH;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign out_valid_next = put_fire || (out_valid_reg && out_stall);

    // ------------------------------------------------------------------
    // Control and parameter registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_LOAD;
            load_cnt_reg      <= '0;
            glyph_width_reg   <= 6'd16;
            bold_enable_reg   <= 1'b0;
            italic_enable_reg <= 1'b0;
            w_reg             <= 6'd1;
            d_reg             <= 6'd1;
            smax_reg          <= 4'd1;
            qinc_reg          <= 5'd0;
            rinc_reg          <= 5'd0;
            bold_reg          <= 1'b0;
            italic_reg        <= 1'b0;
            row_reg           <= 6'd0;
            syq_reg           <= 5'd0;
            syr_reg           <= 6'd0;
            shq_reg           <= 4'd0;
            shr_reg           <= 6'd0;
            col_reg           <= 5'd0;
            cq_reg            <= 5'd0;
            cr_reg            <= 6'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            w_reg         <= w_next;
            d_reg         <= d_next;
            smax_reg      <= smax_next;
            qinc_reg      <= qinc_next;
            rinc_reg      <= rinc_next;
            bold_reg      <= bold_next;
            italic_reg    <= italic_next;
            row_reg       <= row_next;
            syq_reg       <= syq_next;
            syr_reg       <= syr_next;
            shq_reg       <= shq_next;
            shr_reg       <= shr_next;
            col_reg       <= col_next;
            cq_reg        <= cq_next;
            cr_reg        <= cr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_GLYPH_WIDTH:   glyph_width_reg   <= cfg_data;
                    CFG_BOLD_ENABLE:   bold_enable_reg   <= cfg_data[0];
                    CFG_ITALIC_ENABLE: italic_enable_reg <= cfg_data[0];
                    default:           ;  // unmapped index, ignored
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers and glyph store
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (put_fire)
        begin
            pixel_row_reg  <= acc_reg;
            row_number_reg <= row_reg;
            last_row_reg   <= is_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            glyph_mem[load_cnt_reg] <= row_bits;
        rd_data_reg <= glyph_mem[syq_reg];
    end

    assign out_valid  = out_valid_reg;
    assign pixel_row  = pixel_row_reg;
    assign row_number = row_number_reg;
    assign last_row   = last_row_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // rows go out in order, one step at a time
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        put_fire && !is_last |=> row_reg == $past(row_reg) + 6'd1)
        else $error("output row number skipped");

    // stepper remainders stay below their divisors during column stepping
    a_dda_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COLS |-> syr_reg < w_reg && cr_reg < w_reg)
        else $error("coordinate remainder out of range");

    a_shear_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_LOAD |-> shr_reg < d_reg || (shr_reg == 6'd0))
        else $error("shear remainder out of range");

    // emission start wraps the load slot to 0 and leaves load, so no source row is taken
    a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> state_reg == ST_FETCH && load_cnt_reg == '0)
        else $error("emission start out of step with load slot");

endmodule

`default_nettype wire

// File: verif/glyph_raster_scaler_tb.sv
// ============================================================================
// glyph_raster_scaler_tb - self-checking testbench for the glyph raster scaler
// Loads 16x32 source glyphs row by row under a range of width, bold and
// italic settings and checks every scaled output word against a local
// nearest-neighbor predictor, or against a typed word for some directed
// glyphs. It opens with a table of directed glyphs and follows with random
// glyphs, with random gaps on the input side and random stall on the output side.
// ============================================================================
`default_nettype none

module glyph_raster_scaler_tb
    import grs_pkg::*;
();

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int RANDOM_ROWS     = 150;
    localparam int SETTLE_CYCLES   = 8;     // margin; block is back in load once its last word is out
    localparam int END_CYCLES      = 100;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int LONG_HOLD       = 400;   // output hold-off that backs up the input
    localparam int PRESSURE_PHASE  = 2;
    localparam int MAX_REPORTS     = 60;
    localparam int DIRECTED_GLYPHS = 8;

    // Index past the end of the register list; writes there must be dropped
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum int {FILL_RANDOM, FILL_SPARSE, FILL_DENSE, FILL_SINGLE} fill_t;

    // One scaled output word
    typedef struct {
        logic [31:0] pixel_row;
        logic [5:0]  row_number;
        logic        last_row;
    } scaled_row_t;

    // One directed glyph: settings, row pattern and, where it is obvious,
    // the pixel row that every output word must carry
    typedef struct {
        bit          load_cfg;      // 0: run with the reset settings
        logic [5:0]  width_val;
        bit          bold;
        bit          italic;
        bit          junk_write;    // also write the unused register index
        logic [15:0] seed;          // every source row, or its starting point
        bit          walk;          // row i is the seed rotated right by i
        bit          typed;         // expected words given below
        logic [31:0] typed_pixel;
        int          typed_rows;
    } glyph_case_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] row_bits;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] pixel_row;
    logic [5:0]  row_number;
    logic        last_row;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;

    // Predictor state: copy of the source glyph, the next load slot and the
    // register values as the block should hold them
    logic [15:0] glyph_copy [SRC_HEIGHT];
    int          load_slot;
    logic [5:0]  width_reg;
    logic        bold_reg;
    logic        italic_reg;

    // Scaled words still owed by the block, oldest first
    scaled_row_t expected_rows [$];

    // Directed glyphs with typed expectations bypass the predictor
    bit          use_typed;
    logic [31:0] typed_pixel;
    int          typed_rows;

    bit gaps_enabled;
    int long_hold_cycles;
    int error_count;
    int cycle_count;

    // Reset glyph first (width 16), then the width corner cases, bold and
    // italic. The walking patterns put every source column through the
    // predictor; 0x0001 checks that bold drops the bit shifted past column 15.
    glyph_case_t directed_cases [DIRECTED_GLYPHS] = '{
        '{1'b0, 6'd16, 1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b1, 32'hFFFF_0000, 32},
        '{1'b1, 6'd0,  1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0, 1'b1, 32'h8000_0000, 2},
        '{1'b1, 6'd63, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b1, 32'h0000_0000, 64},
        '{1'b1, 6'd33, 1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 64},
        '{1'b1, 6'd32, 1'b1, 1'b0, 1'b0, 16'h8000, 1'b1, 1'b0, 32'h0, 0},
        '{1'b1, 6'd16, 1'b1, 1'b1, 1'b1, 16'h0001, 1'b1, 1'b0, 32'h0, 0},
        '{1'b1, 6'd7,  1'b0, 1'b1, 1'b0, 16'h0080, 1'b1, 1'b0, 32'h0, 0},
        '{1'b1, 6'd1,  1'b1, 1'b1, 1'b0, 16'hFFFF, 1'b0, 1'b0, 32'h0, 0}
    };

    glyph_raster_scaler uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .row_bits   (row_bits),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_row  (pixel_row),
        .row_number (row_number),
        .last_row   (last_row),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Width 0 behaves as 1, anything past MAX_WIDTH clamps
    function automatic int effective_width(logic [5:0] v);
        if (v == 6'd0)
            return 1;
        if (int'(v) > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(v);
    endfunction

    // Nearest-neighbor column pick; columns left of the shear stay blank
    function automatic logic [31:0] scale_line(logic [15:0] src, int w, int shear);
        logic [31:0] line;
        int          sx;
        line = '0;
        for (int c = 0; c < w; c++)
        begin
            if (c >= shear)
            begin
                sx = (c - shear) * SRC_WIDTH / w;
                if (src[SRC_WIDTH - 1 - sx])
                    line[31 - c] = 1'b1;
            end
        end
        return line;
    endfunction

    // Queue every word of the glyph just completed, using the settings held now
    function automatic void push_scaled_glyph();
        int          w;
        int          h;
        int          slant;
        int          shear;
        int          n;
        logic [15:0] src;
        scaled_row_t e;
        w     = effective_width(width_reg);
        h     = 2 * w;
        slant = (w / 4 < 1) ? 1 : w / 4;
        n     = use_typed ? typed_rows : h;
        for (int r = 0; r < n; r++)
        begin
            src = glyph_copy[r * SRC_HEIGHT / h];
            if (bold_reg)
                src = src | (src >> 1);
            shear = italic_reg ? (h - 1 - r) * slant / (h - 1) : 0;
            e.pixel_row  = use_typed ? typed_pixel : scale_line(src, w, shear);
            e.row_number = 6'(r);
            e.last_row   = (r == n - 1);
            expected_rows.push_back(e);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        if (!gaps_enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] random_row(fill_t fill);
        case (fill)
            FILL_SPARSE: return 16'($urandom) & 16'($urandom);
            FILL_DENSE:  return 16'($urandom) | 16'($urandom);
            FILL_SINGLE: return 16'h0001 << $urandom_range(0, 15);
            default:     return 16'($urandom);
        endcase
    endfunction

    // Offer one source row and wait for it to be taken. Valid stays high
    // into the next word unless a gap follows.
    task automatic send_row(logic [15:0] v);
        int gap;
        in_valid <= 1'b1;
        row_bits <= v;
        do
            @(posedge clk);
        while (in_stall);
        glyph_copy[load_slot] = v;
        if (load_slot == SRC_HEIGHT - 1)
        begin
            load_slot = 0;
            push_scaled_glyph();
        end
        else
            load_slot++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Caller lowers cfg_valid after the last write of a batch
    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_GLYPH_WIDTH:   width_reg  = val;
            CFG_BOLD_ENABLE:   bold_reg   = val[0];
            CFG_ITALIC_ENABLE: italic_reg = val[0];
            default: ;
        endcase
    endtask

    // Random upper bits on the flag writes; only bit 0 counts
    function automatic logic [5:0] flag_data(bit flag);
        return {5'($urandom), flag};
    endfunction

    function automatic logic [5:0] random_width();
        if ($urandom_range(0, 9) == 0)
            return 6'($urandom_range(33, 63));
        if ($urandom_range(0, 3) == 0)
            return 6'($urandom_range(17, 32));
        return 6'($urandom_range(0, 16));
    endfunction

    // Drain, then give the sequencer time to settle before touching registers
    task automatic wait_idle();
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH %s: got %h, expected %h", what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Output side: stall pattern and checking
    // ------------------------------------------------------------------------

    // Each pass sets out_stall once and holds it for the run drawn in that
    // pass. A long hold-off requested by the stimulus is counted out here.
    initial
    begin
        int run;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_cycles > 0)
            begin
                run = long_hold_cycles;
                long_hold_cycles = 0;
                out_stall <= 1'b1;
            end
            else if (gaps_enabled && $urandom_range(0, 2) == 0)
            begin
                run = pick_gap() + 1;
                out_stall <= 1'b1;
            end
            else
            begin
                run = $urandom_range(1, 12);
                out_stall <= 1'b0;
            end
            repeat (run) @(posedge clk);
        end
    end

    // Every accepted word is matched against the oldest expectation
    always @(posedge clk)
    begin
        scaled_row_t e;
        if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall)
        begin
            if (expected_rows.size() == 0)
                report_mismatch("word with none expected", pixel_row, 32'h0);
            else
            begin
                e = expected_rows.pop_front();
                if (pixel_row !== e.pixel_row)
                    report_mismatch($sformatf("pixel_row of row %0d", e.row_number),
                                    pixel_row, e.pixel_row);
                if (row_number !== e.row_number)
                    report_mismatch("row_number", 32'(row_number), 32'(e.row_number));
                if (last_row !== e.last_row)
                    report_mismatch($sformatf("last_row of row %0d", e.row_number),
                                    32'(last_row), 32'(e.last_row));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        glyph_case_t dc;
        logic [31:0] rot;
        fill_t       fill;
        int          n;
        int          sent;
        int          phase;

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        row_bits         = '0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_GLYPH_WIDTH;
        cfg_data         = '0;
        load_slot        = 0;
        width_reg        = 6'd16;
        bold_reg         = 1'b0;
        italic_reg       = 1'b0;
        use_typed        = 1'b0;
        typed_pixel      = '0;
        typed_rows       = 0;
        gaps_enabled     = 1'b0;
        long_hold_cycles = 0;
        error_count      = 0;
        cycle_count      = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed glyphs, no gaps so the timing is easy to follow
        for (int i = 0; i < DIRECTED_GLYPHS; i++)
        begin
            dc = directed_cases[i];
            if (dc.load_cfg)
            begin
                write_reg(CFG_GLYPH_WIDTH, dc.width_val);
                write_reg(CFG_BOLD_ENABLE, flag_data(dc.bold));
                write_reg(CFG_ITALIC_ENABLE, flag_data(dc.italic));
                // would turn width 0 into 5 if the unused index leaked through
                if (dc.junk_write)
                    write_reg(CFG_UNUSED, 6'd5);
                cfg_valid <= 1'b0;
            end
            use_typed   = dc.typed;
            typed_pixel = dc.typed_pixel;
            typed_rows  = dc.typed_rows;
            for (int j = 0; j < SRC_HEIGHT; j++)
            begin
                rot = {dc.seed, dc.seed} >> (j % SRC_WIDTH);
                send_row(dc.walk ? rot[15:0] : dc.seed);
            end
            in_valid <= 1'b0;
            wait_idle();
            use_typed = 1'b0;
        end

        // Random phases. Most complete a glyph; some stop part way so the
        // registers change between loads. One phase holds the output off
        // long enough that the block backs up and stalls its input.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ROWS || load_slot != 0)
        begin
            gaps_enabled = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_GLYPH_WIDTH, random_width());
            if ($urandom_range(0, 1) != 0)
                write_reg(CFG_BOLD_ENABLE, flag_data(1'($urandom_range(0, 1))));
            if ($urandom_range(0, 1) != 0)
                write_reg(CFG_ITALIC_ENABLE, flag_data(1'($urandom_range(0, 1))));
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_UNUSED, 6'($urandom));
            cfg_valid <= 1'b0;

            if (sent >= RANDOM_ROWS)
                n = SRC_HEIGHT - load_slot;
            else if (phase == PRESSURE_PHASE)
            begin
                long_hold_cycles = LONG_HOLD;
                n = 2 * SRC_HEIGHT - load_slot;
            end
            else if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, 40);
            else
                n = SRC_HEIGHT - load_slot;

            fill = fill_t'($urandom_range(0, 3));
            for (int k = 0; k < n; k++)
            begin
                send_row(random_row(fill));
                sent++;
            end
            in_valid <= 1'b0;
            wait_idle();
            phase++;
        end

        repeat (END_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
